>>> rtl/tant_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tant_pkg: shared types and constants
// Request and result words, controller states, command and status groups,
// field codes and default sizes for the turmite step engine.
// ---------------------------------------------------------------------------
package tant_pkg;

  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_NUM_COLORS = 16;

  localparam int COLOR_W = 4;
  localparam int CFG_W   = 64;

  // register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TURN_TABLE  = 2'd2;
  localparam logic [1:0] CFG_NEXT_COLOR  = 2'd3;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_PLACE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BOUNDARY = 2'd1;
  localparam logic [1:0] ST_PLACE_OOB = 2'd2;

  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  // heading + turn - 1, so the bias is minus one quarter
  localparam logic [1:0] TURN_BIAS = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] place_col;
    logic [7:0] place_row;
    logic [1:0] place_heading;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         ant_col;
    logic [7:0]         ant_row;
    logic [1:0]         ant_heading;
    logic [COLOR_W-1:0] written_color;
  } res_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

>>> rtl/tant_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tant_ctrl: sequencing controller
// Runs the grid clearing pass after reset, then accepts one request word
// and passes it to the datapath through the execute state.
// ---------------------------------------------------------------------------
module tant_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tant_pkg::stat_t stat_i,
  output tant_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  tant_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tant_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      tant_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = tant_pkg::S_IDLE;
        end
      end
      tant_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = tant_pkg::S_EXEC;
        end
      end
      tant_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = tant_pkg::S_IDLE;
      end
      default: begin
        state_d = tant_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/tant_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tant_dp: grid memory and ant datapath
// Holds the rule registers, the ant position and heading, the color grid
// and the result register; does the read, turn, repaint and move.
// ---------------------------------------------------------------------------
module tant_dp #(
  parameter int MAX_COLS   = tant_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = tant_pkg::DEF_MAX_ROWS,
  parameter int NUM_COLORS = tant_pkg::DEF_NUM_COLORS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tant_pkg::cmd_t             cmd_i,
  output tant_pkg::stat_t            stat_o,
  input  tant_pkg::req_t             req_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tant_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       res_valid_o,
  output tant_pkg::res_t             res_o
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = tant_pkg::COLOR_W;
  localparam logic [8:0] LIM_C = 9'((MAX_COLS < 256) ? MAX_COLS : 256);
  localparam logic [8:0] LIM_R = 9'((MAX_ROWS < 256) ? MAX_ROWS : 256);
  localparam logic [CW:0] NC   = (CW+1)'(NUM_COLORS);

  logic [8:0]  grid_width_q, grid_height_q;
  logic [31:0] turn_table_q;
  logic [63:0] next_color_q;

  logic [7:0] pos_col_q, pos_row_q, pos_col_d, pos_row_d;
  logic [1:0] heading_q, heading_d;

  tant_pkg::req_t req_q;
  logic [CW-1:0]  rd_q;
  logic [AW-1:0]  clr_cnt_q;

  logic           res_valid_q;
  tant_pkg::res_t res_q;

  logic [CW-1:0] mem [DEPTH];

  logic [AW-1:0] cur_addr, wr_addr;
  logic [CW-1:0] wr_data;
  logic          wr_en;

  logic [8:0]    w_eff, h_eff;
  logic [1:0]    turn;
  logic [CW-1:0] repl;
  logic [CW:0]   repl_m;
  logic [8:0]    nc, nr;
  logic          move_ok;
  tant_pkg::res_t res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 9'd256;
      grid_height_q <= 9'd256;
      turn_table_q  <= '0;
      next_color_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tant_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[8:0];
        tant_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[8:0];
        tant_pkg::CFG_TURN_TABLE:  turn_table_q  <= cfg_data_i[31:0];
        tant_pkg::CFG_NEXT_COLOR:  next_color_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // effective grid size
  always_comb begin
    w_eff = (grid_width_q > LIM_C) ? LIM_C : grid_width_q;
    if (w_eff == 9'd0) begin
      w_eff = 9'd1;
    end
    h_eff = (grid_height_q > LIM_R) ? LIM_R : grid_height_q;
    if (h_eff == 9'd0) begin
      h_eff = 9'd1;
    end
  end

  // position always stays below the maximum size
  assign cur_addr = AW'(32'(pos_row_q) * 32'(MAX_COLS) + 32'(pos_col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == AW'(DEPTH - 1));

  always_comb begin
    turn   = turn_table_q[{rd_q, 1'b0} +: 2];
    repl   = next_color_q[{rd_q, 2'b00} +: CW];
    repl_m = {1'b0, repl};
    for (int k = 0; k < 8; k++) begin
      if (repl_m >= NC) begin
        repl_m = repl_m - NC;
      end
    end
  end

  always_comb begin
    pos_col_d = pos_col_q;
    pos_row_d = pos_row_q;
    heading_d = heading_q;
    nc        = {1'b0, pos_col_q};
    nr        = {1'b0, pos_row_q};
    move_ok   = 1'b1;
    res_d     = '0;
    if (req_q.req_type == tant_pkg::REQ_PLACE) begin
      if ({1'b0, req_q.place_col} < w_eff && {1'b0, req_q.place_row} < h_eff) begin
        pos_col_d = req_q.place_col;
        pos_row_d = req_q.place_row;
        heading_d = req_q.place_heading;
        res_d.status = tant_pkg::ST_OK;
      end else begin
        res_d.status = tant_pkg::ST_PLACE_OOB;
      end
    end else begin
      heading_d = heading_q + turn + tant_pkg::TURN_BIAS;
      case (heading_d)
        tant_pkg::HEAD_NORTH: begin
          if (pos_row_q == 8'd0) begin
            move_ok = 1'b0;
          end else begin
            nr = nr - 9'd1;
          end
        end
        tant_pkg::HEAD_EAST:  nc = nc + 9'd1;
        tant_pkg::HEAD_SOUTH: nr = nr + 9'd1;
        tant_pkg::HEAD_WEST: begin
          if (pos_col_q == 8'd0) begin
            move_ok = 1'b0;
          end else begin
            nc = nc - 9'd1;
          end
        end
        default: move_ok = 1'b0;
      endcase
      if (nc >= w_eff || nr >= h_eff) begin
        move_ok = 1'b0;
      end
      if (move_ok) begin
        pos_col_d    = nc[7:0];
        pos_row_d    = nr[7:0];
        res_d.status = tant_pkg::ST_OK;
      end else begin
        res_d.status = tant_pkg::ST_BOUNDARY;
      end
      res_d.written_color = repl_m[CW-1:0];
    end
    res_d.ant_col     = pos_col_d;
    res_d.ant_row     = pos_row_d;
    res_d.ant_heading = heading_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_col_q   <= '0;
      pos_row_q   <= '0;
      heading_q   <= tant_pkg::HEAD_NORTH;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        pos_col_q <= pos_col_d;
        pos_row_q <= pos_row_d;
        heading_q <= heading_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  // single write port shared by clearing pass and repaint
  assign wr_en   = cmd_i.clear || (cmd_i.exec && req_q.req_type == tant_pkg::REQ_STEP);
  assign wr_addr = cmd_i.clear ? clr_cnt_q : cur_addr;
  assign wr_data = cmd_i.clear ? '0 : repl_m[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[cur_addr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/turmite_ant_step.sv
`timescale 1ns / 1ps
// The accept cycle reads the grid memory and the execute state writes the
// repaint and registers the result and its strobe; busy_o is high in the
// execute state, so no new word is taken until the last one has executed.
// Reset: the grid memory is cleared one cell per cycle, with busy_o high;
// configuration writes are taken meanwhile.
// Results are strobed for one cycle on res_valid_o; the receiver cannot stall.
// ---------------------------------------------------------------------------
// turmite_ant_step: multi-color ant on a bounded grid
// Place and step requests on a grid of colored cells held in on-chip memory,
// with per-color turn and repaint rules in configuration registers.
// ---------------------------------------------------------------------------
module turmite_ant_step #(
  parameter int MAX_COLS   = tant_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = tant_pkg::DEF_MAX_ROWS,
  parameter int NUM_COLORS = tant_pkg::DEF_NUM_COLORS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  tant_pkg::req_t             req_i,
  output logic                       res_valid_o,
  output tant_pkg::res_t             res_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tant_pkg::CFG_W-1:0] cfg_data_i
);

  tant_pkg::cmd_t  cmd;
  tant_pkg::stat_t stat;

  tant_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  tant_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .NUM_COLORS (NUM_COLORS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

>>> verif/turmite_ant_step_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// turmite_ant_step_chk: result checker for the turmite step engine
// Watches the request, result and register write ports, keeps its own grid,
// ant and register copies, works out each expected result word and compares
// every strobed result with the oldest one still due.
// ---------------------------------------------------------------------------
module turmite_ant_step_chk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  tant_pkg::req_t             req_i,
  input  logic                       res_valid_i,
  input  tant_pkg::res_t             res_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tant_pkg::CFG_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         pending_o
);

  localparam int GRID_CELLS = tant_pkg::DEF_MAX_COLS * tant_pkg::DEF_MAX_ROWS;

  logic [tant_pkg::COLOR_W-1:0] floor_color [GRID_CELLS];
  logic [7:0]                   ant_col;
  logic [7:0]                   ant_row;
  logic [1:0]                   ant_head;
  logic [8:0]                   width_reg;
  logic [8:0]                   height_reg;
  logic [31:0]                  turn_reg;
  logic [63:0]                  repaint_reg;
  tant_pkg::res_t               due_reports [$];

  function automatic logic [8:0] span(logic [8:0] reg_val);
    if (reg_val > 9'd256) return 9'd256;
    if (reg_val == 9'd0) return 9'd1;
    return reg_val;
  endfunction

  // advances the ant by one word and returns the report it should give
  function automatic tant_pkg::res_t walk_ant(tant_pkg::req_t rq);
    tant_pkg::res_t               rs;
    logic [8:0]                   w;
    logic [8:0]                   h;
    logic [15:0]                  spot;
    logic [tant_pkg::COLOR_W-1:0] hue;
    logic [1:0]                   turn;
    logic [tant_pkg::COLOR_W-1:0] repl;
    logic [8:0]                   nc;
    logic [8:0]                   nr;
    logic                         ok;
    w  = span(width_reg);
    h  = span(height_reg);
    rs = '0;
    rs.status = tant_pkg::ST_OK;
    if (rq.req_type == tant_pkg::REQ_PLACE) begin
      if ({1'b0, rq.place_col} < w && {1'b0, rq.place_row} < h) begin
        ant_col  = rq.place_col;
        ant_row  = rq.place_row;
        ant_head = rq.place_heading;
      end else begin
        rs.status = tant_pkg::ST_PLACE_OOB;
      end
    end else begin
      spot = {ant_row, ant_col};
      hue  = floor_color[spot];
      turn = turn_reg[2*hue +: 2];
      repl = repaint_reg[4*hue +: 4];
      ant_head = ant_head + turn + tant_pkg::TURN_BIAS;
      floor_color[spot] = repl;
      rs.written_color = repl;
      nc = {1'b0, ant_col};
      nr = {1'b0, ant_row};
      ok = 1'b1;
      case (ant_head)
        tant_pkg::HEAD_NORTH: begin
          if (ant_row == 8'd0) ok = 1'b0;
          else nr = nr - 9'd1;
        end
        tant_pkg::HEAD_EAST:  nc = nc + 9'd1;
        tant_pkg::HEAD_SOUTH: nr = nr + 9'd1;
        default: begin
          if (ant_col == 8'd0) ok = 1'b0;
          else nc = nc - 9'd1;
        end
      endcase
      if (ok && (nc >= w || nr >= h)) ok = 1'b0;
      if (ok) begin
        ant_col = nc[7:0];
        ant_row = nr[7:0];
      end else begin
        rs.status = tant_pkg::ST_BOUNDARY;
      end
    end
    rs.ant_col     = ant_col;
    rs.ant_row     = ant_row;
    rs.ant_heading = ant_head;
    return rs;
  endfunction

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) floor_color[i] = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    tant_pkg::res_t want;
    if (!rst_ni) begin
      ant_col     = '0;
      ant_row     = '0;
      ant_head    = tant_pkg::HEAD_NORTH;
      width_reg   = 9'd256;
      height_reg  = 9'd256;
      turn_reg    = '0;
      repaint_reg = '0;
      due_reports.delete();
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tant_pkg::CFG_GRID_WIDTH:  width_reg   = cfg_data_i[8:0];
          tant_pkg::CFG_GRID_HEIGHT: height_reg  = cfg_data_i[8:0];
          tant_pkg::CFG_TURN_TABLE:  turn_reg    = cfg_data_i[31:0];
          default:                   repaint_reg = cfg_data_i;
        endcase
      end
      if (res_valid_i) begin
        if (due_reports.size() == 0) begin
          errors_o++;
          $display("%0t: result word with nothing due: exp none, got %h", $time, res_i);
        end else begin
          want = due_reports.pop_front();
          if (res_i.status !== want.status || res_i.ant_col !== want.ant_col ||
              res_i.ant_row !== want.ant_row || res_i.ant_heading !== want.ant_heading ||
              res_i.written_color !== want.written_color) begin
            errors_o++;
            $display({"%0t: mismatch exp st %0d col %0d row %0d head %0d color %0d,",
                      " got st %0d col %0d row %0d head %0d color %0d"},
                     $time, want.status, want.ant_col, want.ant_row, want.ant_heading,
                     want.written_color, res_i.status, res_i.ant_col, res_i.ant_row,
                     res_i.ant_heading, res_i.written_color);
          end
        end
      end
      if (start_i && !busy_i) due_reports.push_back(walk_ant(req_i));
      pending_o = due_reports.size();
    end
  end

endmodule

>>> verif/turmite_ant_step_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// turmite_ant_step_tb: testbench top for the turmite step engine
// Resets once, runs a directed set of place and step words over edge cells
// and odd register values, then random phases of mostly step words under
// varied grid sizes and rule tables, sent in bursts with random gaps.
// ---------------------------------------------------------------------------
module turmite_ant_step_tb;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       start_i    = 1'b0;
  logic                       busy_o;
  tant_pkg::req_t             req_i      = '0;
  logic                       res_valid_o;
  tant_pkg::res_t             res_o;
  logic                       cfg_we_i   = 1'b0;
  logic [1:0]                 cfg_idx_i  = tant_pkg::CFG_GRID_WIDTH;
  logic [tant_pkg::CFG_W-1:0] cfg_data_i = '0;
  int                         errors;
  int                         pending;
  int                         in_cols = 256;
  int                         in_rows = 256;

  turmite_ant_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  turmite_ant_step_chk chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [tant_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_grid(logic [8:0] w, logic [8:0] h, logic [31:0] turns,
                          logic [63:0] repaint);
    write_reg(tant_pkg::CFG_GRID_WIDTH, {55'd0, w});
    write_reg(tant_pkg::CFG_GRID_HEIGHT, {55'd0, h});
    write_reg(tant_pkg::CFG_TURN_TABLE, {32'd0, turns});
    write_reg(tant_pkg::CFG_NEXT_COLOR, repaint);
    in_cols = (w == 9'd0) ? 1 : (w > 9'd256) ? 256 : int'(w);
    in_rows = (h == 9'd0) ? 1 : (h > 9'd256) ? 256 : int'(h);
  endtask

  // register writes only once every due result is back
  task automatic drain();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(tant_pkg::req_t w);
    start_i = 1'b1;
    req_i   = w;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  function automatic tant_pkg::req_t word_of(logic t, logic [7:0] c, logic [7:0] r,
                                             logic [1:0] h);
    tant_pkg::req_t w;
    w.req_type      = t;
    w.place_col     = c;
    w.place_row     = r;
    w.place_heading = h;
    return w;
  endfunction

  function automatic tant_pkg::req_t rand_word();
    tant_pkg::req_t w;
    w.place_col     = 8'($urandom);
    w.place_row     = 8'($urandom);
    w.place_heading = 2'($urandom);
    w.req_type      = ($urandom_range(0, 99) < 12) ? tant_pkg::REQ_PLACE : tant_pkg::REQ_STEP;
    if (w.req_type == tant_pkg::REQ_PLACE && $urandom_range(0, 1) == 0) begin
      w.place_col = 8'($urandom_range(0, in_cols - 1));
      w.place_row = 8'($urandom_range(0, in_rows - 1));
    end
    return w;
  endfunction

  initial begin
    int left;
    int burst;
    int gap;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // every turn code and the (0,0) and (255,255) corners on the full grid
    set_grid(9'd256, 9'd256, 32'hE4E4_E4E4, 64'h0FED_CBA9_8765_4321);
    @(negedge clk_i);
    send(word_of(tant_pkg::REQ_PLACE, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_STEP, 8'hFF, 8'hFF, tant_pkg::HEAD_WEST));
    send(word_of(tant_pkg::REQ_STEP, 8'h00, 8'h00, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_STEP, 8'hAA, 8'h55, tant_pkg::HEAD_EAST));
    send(word_of(tant_pkg::REQ_STEP, 8'h55, 8'hAA, tant_pkg::HEAD_SOUTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd255, 8'd255, tant_pkg::HEAD_EAST));
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd255, 8'd255, tant_pkg::HEAD_EAST));
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd255, 8'd255, tant_pkg::HEAD_SOUTH));
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd200, 8'd200, tant_pkg::HEAD_EAST));
    drain();

    // zero sizes shrink to one cell while the ant sits far outside
    set_grid(9'd0, 9'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    @(negedge clk_i);
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd0, 8'd0, tant_pkg::HEAD_WEST));
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd1, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd0, 8'd1, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd255, 8'd255, tant_pkg::HEAD_SOUTH));
    drain();

    // oversized registers clamp to the full grid
    set_grid(9'd511, 9'd300, 32'h0, 64'h0);
    @(negedge clk_i);
    send(word_of(tant_pkg::REQ_PLACE, 8'd255, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    send(word_of(tant_pkg::REQ_PLACE, 8'd0, 8'd255, tant_pkg::HEAD_SOUTH));
    send(word_of(tant_pkg::REQ_STEP, 8'd0, 8'd0, tant_pkg::HEAD_NORTH));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_grid(9'd256, 9'd256, $urandom, {$urandom, $urandom});
        1: set_grid(9'd1, 9'd1, $urandom, {$urandom, $urandom});
        2: set_grid(9'd511, 9'd0, $urandom, {$urandom, $urandom});
        3: set_grid(9'd0, 9'd300, $urandom, {$urandom, $urandom});
        4: set_grid(9'd24, 9'd24, 32'h0000_0002, 64'h0000_0000_0000_0001);
        5: set_grid(9'($urandom_range(2, 20)), 9'($urandom_range(2, 20)),
                    32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        default: set_grid(9'($urandom_range(2, 24)), 9'($urandom_range(2, 24)),
                          $urandom, {$urandom, $urandom});
      endcase
      @(negedge clk_i);
      left = 235;
      while (left > 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        for (int b = 0; b < burst && left > 0; b++) begin
          send(rand_word());
          left--;
        end
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        if (gap > 0) begin
          start_i = 1'b0;
          req_i   = rand_word();
          repeat (gap) @(negedge clk_i);
        end
      end
      drain();
    end

    for (int k = 0; k < 2000 && pending != 0; k++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tant_pkg.sv
rtl/tant_ctrl.sv
rtl/tant_dp.sv
rtl/turmite_ant_step.sv
verif/turmite_ant_step_chk.sv
verif/turmite_ant_step_tb.sv
